FILE: rtl/agpc_pkg.sv
// Shared constants and types for the antialiased glyph pixel combiner.
`timescale 1ns / 1ps

package agpc_pkg;

	// Packed 10-10-10 color helpers
	localparam logic [31:0] CH_MASK    = 32'h3fcf_f3fc;
	localparam logic [31:0] CARRY_BITS = 32'h4010_0400;
	localparam logic [31:0] CH_ONE     = 32'h0040_1004;
	localparam logic [31:0] INV_BASE   = 32'h1fc7_f1fc;

	localparam int unsigned NUM_LEVELS = 7;
	localparam int unsigned ADDR_W     = 5;
	localparam logic [2:0]  REG_ENERGY = 3'd7;

	typedef enum logic [2:0] {
		MODE_COPY   = 3'd0,
		MODE_OVER   = 3'd1,
		MODE_MAX    = 3'd2,
		MODE_MIN    = 3'd3,
		MODE_ADD    = 3'd4,
		MODE_SUB    = 3'd5,
		MODE_BLEND  = 3'd6,
		MODE_INVERT = 3'd7
	} mode_t;

	typedef struct packed {
		logic [2:0] mode;
		logic [2:0] coverage;
		logic [7:0] dest_red;
		logic [7:0] dest_green;
		logic [7:0] dest_blue;
	} pixel_t;

	typedef struct packed {
		logic        write_pixel;
		logic [14:0] rgb555_index;
	} result_t;

endpackage

FILE: rtl/agpc_combine.sv
// Combinational pixel combine datapath: one pixel and its level color to one result.
`timescale 1ns / 1ps

module agpc_combine (
	input  agpc_pkg::pixel_t  pix,
	input  logic [31:0]       level_color,
	input  logic [9:0]        energy_limit,
	output agpc_pkg::result_t res
);
	import agpc_pkg::*;

	logic [9:0]  sum;
	logic [3:0]  wgt;
	logic [3:0]  inv_wgt;
	logic [31:0] dest_wide;
	logic [31:0] dest_half;
	logic [31:0] dest_half8;
	logic [31:0] half_prod;
	logic [31:0] over_val;
	logic [31:0] add_sum;
	logic [31:0] add_carry;
	logic [31:0] add_fill;
	logic [31:0] sub_sum;
	logic [31:0] sub_carry;
	logic [31:0] sub_fill;
	logic [31:0] blend_tmp;
	logic [31:0] inv_base;
	logic [31:0] inv_prod;
	logic [31:0] color;
	logic        skip;
	mode_t       mode;

	assign mode = mode_t'(pix.mode);
	assign sum  = {2'b00, pix.dest_red} + {2'b00, pix.dest_green} + {2'b00, pix.dest_blue};

	// Full coverage counts as weight 8 so the destination drops out.
	assign wgt     = (pix.coverage == 3'd7) ? 4'd8 : {1'b0, pix.coverage};
	assign inv_wgt = 4'd8 - wgt;

	assign dest_wide = {2'b00, pix.dest_red, 2'b00, pix.dest_green, 2'b00, pix.dest_blue, 2'b00};
	assign dest_half = {5'd0, pix.dest_red[7:1], 3'd0, pix.dest_green[7:1], 3'd0,
		pix.dest_blue[7:1]};
	assign dest_half8 = {dest_half[28:0], 3'b000};

	assign half_prod = dest_half * {28'd0, inv_wgt};
	assign over_val  = level_color + half_prod;

	// Saturating add: a carry out of a channel floods that channel with ones.
	assign add_sum   = (level_color & CH_MASK) + dest_wide;
	assign add_carry = add_sum & CARRY_BITS;
	assign add_fill  = add_carry - (add_carry >> 8);

	// Saturating subtract: a missing carry clears the channel to zero.
	assign sub_sum   = ((level_color & CH_MASK) ^ CH_MASK) + dest_wide - CH_ONE;
	assign sub_carry = sub_sum & CARRY_BITS;
	assign sub_fill  = sub_carry - (sub_carry >> 8);

	assign blend_tmp = over_val & CH_MASK;

	assign inv_base = (INV_BASE - dest_half8) >> 2;
	assign inv_prod = inv_base * {28'd0, wgt};

	always_comb begin
		skip  = 1'b0;
		color = level_color;
		case (mode)
			MODE_COPY: begin
				color = level_color;
			end
			MODE_OVER: begin
				color = over_val;
			end
			MODE_MAX: begin
				skip  = (sum >= energy_limit);
				color = over_val;
			end
			MODE_MIN: begin
				skip  = (sum <= energy_limit);
				color = over_val;
			end
			MODE_ADD: begin
				color = add_sum | add_fill;
			end
			MODE_SUB: begin
				color = sub_sum & sub_fill;
			end
			MODE_BLEND: begin
				color = (blend_tmp >> 1) + {dest_half[29:0], 2'b00};
			end
			MODE_INVERT: begin
				color = dest_half8 + inv_prod;
			end
			default: begin
				color = level_color;
			end
		endcase
	end

	always_comb begin
		if (pix.coverage == 3'd0 || skip) begin
			res.write_pixel  = 1'b0;
			res.rgb555_index = 15'd0;
		end else begin
			res.write_pixel  = 1'b1;
			res.rgb555_index = {color[29:25], color[19:15], color[9:5]};
		end
	end

endmodule

FILE: rtl/antialiased_glyph_pixel_combine_core.sv
// Top level of the antialiased glyph pixel combiner: registers, handshake and pipeline.
`timescale 1ns / 1ps

// Combines one glyph pixel with its destination color and yields a write flag and an
// RGB555 inverse-palette index.
// Input channel: in_valid/in_ready carry one word with mode, coverage and the
// destination red, green and blue. Output channel: out_valid/out_ready carry one word
// with write_pixel and rgb555_index for every input word, in order.
// The APB port holds the seven per-level packed colors (byte addresses 0 to 24) and
// the energy limit (address 28); the user must write it only while no pixel is in
// flight, and the block itself does not enforce this. A pixel word is captured in an
// input register, combined in one pass, and captured in the result register once
// that register is free. Throughput is one pixel per cycle while the receiver does
// not stall, set by the single-pass combine between those two registers.
// When the receiver stalls, the result register holds its word and the input register
// still takes one more word; in_ready drops only when both are full.
// Reset clears both valid flags and all configuration registers to zero.

module antialiased_glyph_pixel_combine_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [agpc_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [2:0]                  mode,
	input  logic [2:0]                  coverage,
	input  logic [7:0]                  dest_red,
	input  logic [7:0]                  dest_green,
	input  logic [7:0]                  dest_blue,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        write_pixel,
	output logic [14:0]                 rgb555_index
);
	import agpc_pkg::*;

	logic [31:0] level_color_q [NUM_LEVELS];
	logic [9:0]  energy_limit_q;
	logic [2:0]  reg_idx;
	logic        cfg_write;

	pixel_t      pix_s1;
	logic        valid_s1;
	logic [31:0] level_sel;
	result_t     res_comb;
	result_t     res_q;
	logic        out_valid_q;
	logic        advance;

	assign pready    = 1'b1;
	assign reg_idx   = paddr[4:2];
	assign cfg_write = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_LEVELS; k++) begin
				level_color_q[k] <= 32'd0;
			end
			energy_limit_q <= 10'd0;
		end else if (cfg_write) begin
			if (reg_idx == REG_ENERGY) begin
				energy_limit_q <= pwdata[9:0];
			end else begin
				level_color_q[reg_idx] <= pwdata;
			end
		end
	end

	always_comb begin
		if (reg_idx == REG_ENERGY) begin
			prdata = {22'd0, energy_limit_q};
		end else begin
			prdata = level_color_q[reg_idx];
		end
	end

	// The result register frees up when it is empty or its word is being taken.
	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			pix_s1.mode       <= mode;
			pix_s1.coverage   <= coverage;
			pix_s1.dest_red   <= dest_red;
			pix_s1.dest_green <= dest_green;
			pix_s1.dest_blue  <= dest_blue;
		end
		if (advance && valid_s1) begin
			res_q <= res_comb;
		end
	end

	// Coverage zero never writes, so its level lookup is a don't-care.
	assign level_sel = (pix_s1.coverage == 3'd0) ? 32'd0
		: level_color_q[pix_s1.coverage - 3'd1];

	agpc_combine u_combine (
		.pix          (pix_s1),
		.level_color  (level_sel),
		.energy_limit (energy_limit_q),
		.res          (res_comb)
	);

	assign out_valid    = out_valid_q;
	assign write_pixel  = res_q.write_pixel;
	assign rgb555_index = res_q.rgb555_index;

endmodule

FILE: verif/pixel_combine_checker.sv
// Checker for the glyph pixel combiner: tracks the registers, predicts and compares.
`timescale 1ns / 1ps

module pixel_combine_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [agpc_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	input  logic [31:0]                 prdata,
	input  logic                        pready,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  logic [2:0]                  mode,
	input  logic [2:0]                  coverage,
	input  logic [7:0]                  dest_red,
	input  logic [7:0]                  dest_green,
	input  logic [7:0]                  dest_blue,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  logic                        write_pixel,
	input  logic [14:0]                 rgb555_index,
	output int                          errors,
	output int                          outstanding
);
	import agpc_pkg::*;

	logic [31:0] level_color [NUM_LEVELS];
	logic [9:0]  energy_limit;
	result_t     expected_results [$];

	initial begin
		errors = 0;
		outstanding = 0;
		energy_limit = '0;
		foreach (level_color[k])
			level_color[k] = '0;
	end

	task automatic report(input string what);
		$display("%0t ns  mismatch: %s", $time, what);
		errors++;
	endtask

	function automatic result_t combine_pixel(input pixel_t px);
		logic [31:0] color;
		logic [31:0] half;
		logic [31:0] wide;
		logic [31:0] carry;
		logic [31:0] weight;
		logic [31:0] inv;
		logic [9:0]  sum;
		logic        over_dest;
		result_t     res;

		res = '0;
		if (px.coverage == 3'd0)
			return res;
		sum = 10'(px.dest_red) + 10'(px.dest_green) + 10'(px.dest_blue);
		color = level_color[px.coverage - 3'd1];
		// Full coverage counts as weight 8 so the destination drops out.
		weight = 32'(px.coverage) + ((32'(px.coverage) + 32'd1) >> 3);
		wide = {2'b00, px.dest_red, 2'b00, px.dest_green, 2'b00, px.dest_blue, 2'b00};
		half = {5'd0, px.dest_red[7:1], 3'd0, px.dest_green[7:1], 3'd0, px.dest_blue[7:1]};
		over_dest = 1'b0;

		case (mode_t'(px.mode))
			MODE_OVER: over_dest = 1'b1;
			MODE_MAX: begin
				if (sum >= energy_limit)
					return res;
				over_dest = 1'b1;
			end
			MODE_MIN: begin
				if (sum <= energy_limit)
					return res;
				over_dest = 1'b1;
			end
			MODE_ADD: begin
				// Channel carries turn into all-ones fills: saturating add.
				color = (color & CH_MASK) + wide;
				carry = color & CARRY_BITS;
				carry = carry - (carry >> 8);
				color = color | carry;
			end
			MODE_SUB: begin
				color = ((color & CH_MASK) ^ CH_MASK) + wide - CH_ONE;
				carry = color & CARRY_BITS;
				carry = carry - (carry >> 8);
				color = color & carry;
			end
			MODE_BLEND: begin
				color = color + half * (32'd8 - weight);
				color = color & CH_MASK;
				color = (color >> 1) + (half << 2);
			end
			MODE_INVERT: begin
				inv = half << 3;
				color = (INV_BASE - inv) >> 2;
				color = inv + color * weight;
			end
			default: ;
		endcase

		if (over_dest)
			color = color + half * (32'd8 - weight);

		res.write_pixel = 1'b1;
		res.rgb555_index = {color[29:25], color[19:15], color[9:5]};
		return res;
	endfunction

	always @(posedge clk) begin : monitor
		pixel_t      px;
		result_t     want;
		logic [2:0]  idx;
		logic [31:0] stored;

		if (arst_n) begin
			idx = paddr[ADDR_W-1:2];
			if (psel && penable && pready) begin
				if (pwrite) begin
					if (idx == REG_ENERGY)
						energy_limit = pwdata[9:0];
					else if (idx < NUM_LEVELS)
						level_color[idx] = pwdata;
				end else begin
					stored = (idx == REG_ENERGY) ? {22'd0, energy_limit} : level_color[idx];
					if (prdata !== stored)
						report($sformatf("register %0d reads %h, expected %h",
							idx, prdata, stored));
				end
			end

			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					report($sformatf("unexpected result word write_pixel=%b index=%h",
						write_pixel, rgb555_index));
				end else begin
					want = expected_results.pop_front();
					if (write_pixel !== want.write_pixel)
						report($sformatf("write_pixel %b, expected %b",
							write_pixel, want.write_pixel));
					if (rgb555_index !== want.rgb555_index)
						report($sformatf("rgb555_index %h, expected %h",
							rgb555_index, want.rgb555_index));
				end
			end

			if (in_valid && in_ready) begin
				px.mode = mode;
				px.coverage = coverage;
				px.dest_red = dest_red;
				px.dest_green = dest_green;
				px.dest_blue = dest_blue;
				expected_results.push_back(combine_pixel(px));
			end
		end
		outstanding <= expected_results.size();
	end

endmodule

FILE: verif/tb.sv
// Testbench top for the glyph pixel combiner: stimulus, register setup and verdict.
`timescale 1ns / 1ps

module tb;
	import agpc_pkg::*;

	typedef enum {CFG_ZERO, CFG_ONES, CFG_RANDOM, CFG_TEXT, CFG_MIXED} cfg_style_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [2:0]        mode = '0;
	logic [2:0]        coverage = '0;
	logic [7:0]        dest_red = '0;
	logic [7:0]        dest_green = '0;
	logic [7:0]        dest_blue = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic              write_pixel;
	logic [14:0]       rgb555_index;
	bit                calm = 1'b0;
	int                errors;
	int                outstanding;

	antialiased_glyph_pixel_combine_core dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .coverage(coverage),
		.dest_red(dest_red), .dest_green(dest_green), .dest_blue(dest_blue),
		.out_valid(out_valid), .out_ready(out_ready),
		.write_pixel(write_pixel), .rgb555_index(rgb555_index)
	);

	pixel_combine_checker watch (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .coverage(coverage),
		.dest_red(dest_red), .dest_green(dest_green), .dest_blue(dest_blue),
		.out_valid(out_valid), .out_ready(out_ready),
		.write_pixel(write_pixel), .rgb555_index(rgb555_index),
		.errors(errors), .outstanding(outstanding)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("** antialiased_glyph_pixel_combine_core: FAILED **");
		$finish;
	end

	// The receiver stalls at random about one time in ten, except during the calm stretch.
	always @(posedge clk) begin
		out_ready <= calm || ($urandom_range(0, 99) >= 10);
	end

	task automatic apb_access(input logic write, input logic [2:0] idx,
		input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= write;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic program_registers(input cfg_style_t style, input logic [9:0] limit);
		cfg_style_t  pick;
		logic [31:0] value;
		logic [7:0]  text_r;
		logic [7:0]  text_g;
		logic [7:0]  text_b;
		int          w;

		text_r = $urandom;
		text_g = $urandom;
		text_b = $urandom;
		for (int k = 0; k < NUM_LEVELS; k++) begin
			pick = style;
			if (style == CFG_MIXED) begin
				case ($urandom_range(0, 9))
					0: pick = CFG_ZERO;
					1: pick = CFG_ONES;
					2, 3, 4: pick = CFG_RANDOM;
					default: pick = CFG_TEXT;
				endcase
			end
			w = k + 1 + ((k + 2) >> 3);
			case (pick)
				CFG_ZERO: value = '0;
				CFG_ONES: value = '1;
				CFG_RANDOM: value = $urandom;
				default: value = {2'b00, 10'((text_r * w) >> 1),
					10'((text_g * w) >> 1), 10'((text_b * w) >> 1)};
			endcase
			apb_access(1'b1, 3'(k), value);
		end
		apb_access(1'b1, REG_ENERGY, {22'd0, limit});
		for (int k = 0; k <= REG_ENERGY; k++)
			apb_access(1'b0, 3'(k), '0);
	endtask

	task automatic send_pixel(input mode_t m, input logic [2:0] cov,
		input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		int gap;

		gap = 0;
		if (!calm && $urandom_range(0, 99) < 3)
			gap = $urandom_range(1, 5);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		coverage <= cov;
		dest_red <= r;
		dest_green <= g;
		dest_blue <= b;
		do @(posedge clk); while (!in_ready);
	endtask

	// Stops the sender until every result word has come back, then lets the pipeline settle.
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [7:0] pick_channel();
		if ($urandom_range(0, 7) == 0)
			return $urandom_range(0, 1) ? 8'hff : 8'h00;
		return 8'($urandom);
	endfunction

	initial begin
		mode_t      m;
		cfg_style_t style;
		logic [9:0] limit;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		program_registers(CFG_TEXT, 10'd300);
		m = m.first();
		do begin
			send_pixel(m, 3'd7, 8'hff, 8'hff, 8'hff);
			send_pixel(m, 3'd1, 8'h00, 8'h00, 8'h00);
			m = m.next();
		end while (m != m.first());
		send_pixel(MODE_OVER, 3'd0, pick_channel(), pick_channel(), pick_channel());
		// Brightness sums right at the energy limit and one below or above it.
		send_pixel(MODE_MAX, 3'd7, 8'd100, 8'd100, 8'd100);
		send_pixel(MODE_MAX, 3'd7, 8'd100, 8'd100, 8'd99);
		send_pixel(MODE_MIN, 3'd5, 8'd100, 8'd100, 8'd100);
		send_pixel(MODE_MIN, 3'd5, 8'd100, 8'd100, 8'd101);
		for (int c = 2; c < 7; c++)
			send_pixel(MODE_BLEND, 3'(c), pick_channel(), pick_channel(), pick_channel());

		for (int phase = 0; phase < 8; phase++) begin
			drain();
			case (phase)
				0: begin
					style = CFG_ONES;
					limit = '1;
				end
				1: begin
					style = CFG_ZERO;
					limit = '0;
				end
				default: begin
					style = CFG_MIXED;
					limit = $urandom_range(0, 1023);
				end
			endcase
			program_registers(style, limit);
			calm = (phase == 4);
			for (int n = 0; n < 200; n++) begin
				if (phase == 3 && n == 100)
					drain();
				send_pixel(mode_t'(3'($urandom)), 3'($urandom),
					pick_channel(), pick_channel(), pick_channel());
			end
		end
		calm = 1'b0;

		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("** antialiased_glyph_pixel_combine_core: PASSED **");
		else
			$display("** antialiased_glyph_pixel_combine_core: FAILED **");
		$finish;
	end

endmodule

FILE: sim.f
rtl/agpc_pkg.sv
rtl/agpc_combine.sv
rtl/antialiased_glyph_pixel_combine_core.sv
verif/pixel_combine_checker.sv
verif/tb.sv
